@@ rtl/core/mts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, constants and the melody table of the tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int TICK_W     = 32;
  localparam int DUR_W      = 16;
  localparam int CMP_W      = 16;
  localparam int PAIR_W     = 7;
  localparam int ROM_AW     = 5;
  localparam int IN_DATA_W  = ((TICK_W + 2 + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CMP_W + 2 + 7) / 8) * 8;

  localparam int TONE_CLOCK = 2000000;

  localparam logic [CMP_W-1:0] CMP_C5 = CMP_W'(TONE_CLOCK / 523 * 2 - 1);
  localparam logic [CMP_W-1:0] CMP_D5 = CMP_W'(TONE_CLOCK / 587 * 2 - 1);
  localparam logic [CMP_W-1:0] CMP_E5 = CMP_W'(TONE_CLOCK / 659 * 2 - 1);
  localparam logic [CMP_W-1:0] CMP_G5 = CMP_W'(TONE_CLOCK / 783 * 2 - 1);
  localparam logic [CMP_W-1:0] CMP_C6 = CMP_W'(TONE_CLOCK / 1046 * 2 - 1);

  localparam logic SEL_BIGBEN = 1'b0;
  localparam logic SEL_SPLASH = 1'b1;

  typedef struct packed {
    logic [CMP_W-1:0] compare;
    logic [DUR_W-1:0] duration;
  } rom_word_t;

  typedef struct packed {
    logic              en;
    logic [ROM_AW-1:0] addr;
  } rom_req_t;

  // Bigben pairs sit at 0..15 and splash pairs at 16..27.
  function automatic rom_word_t melody_word(input logic [ROM_AW-1:0] addr);
    rom_word_t w;
    w = '{compare: CMP_E5, duration: DUR_W'(400)};
    case (addr)
      5'd0:  w = '{CMP_E5, DUR_W'(400)};
      5'd1:  w = '{CMP_C5, DUR_W'(400)};
      5'd2:  w = '{CMP_D5, DUR_W'(400)};
      5'd3:  w = '{CMP_G5, DUR_W'(1200)};
      5'd4:  w = '{CMP_G5, DUR_W'(400)};
      5'd5:  w = '{CMP_D5, DUR_W'(400)};
      5'd6:  w = '{CMP_E5, DUR_W'(400)};
      5'd7:  w = '{CMP_C5, DUR_W'(1200)};
      5'd8:  w = '{CMP_E5, DUR_W'(400)};
      5'd9:  w = '{CMP_D5, DUR_W'(400)};
      5'd10: w = '{CMP_C5, DUR_W'(400)};
      5'd11: w = '{CMP_G5, DUR_W'(1200)};
      5'd12: w = '{CMP_G5, DUR_W'(400)};
      5'd13: w = '{CMP_D5, DUR_W'(400)};
      5'd14: w = '{CMP_E5, DUR_W'(400)};
      5'd15: w = '{CMP_C5, DUR_W'(1200)};
      5'd16: w = '{CMP_C5, DUR_W'(100)};
      5'd17: w = '{CMP_E5, DUR_W'(100)};
      5'd18: w = '{CMP_G5, DUR_W'(200)};
      5'd19: w = '{CMP_E5, DUR_W'(100)};
      5'd20: w = '{CMP_G5, DUR_W'(100)};
      5'd21: w = '{CMP_C6, DUR_W'(600)};
      5'd22: w = '{CMP_C5, DUR_W'(100)};
      5'd23: w = '{CMP_E5, DUR_W'(100)};
      5'd24: w = '{CMP_G5, DUR_W'(200)};
      5'd25: w = '{CMP_E5, DUR_W'(100)};
      5'd26: w = '{CMP_G5, DUR_W'(100)};
      5'd27: w = '{CMP_C6, DUR_W'(800)};
      default: w = '{CMP_E5, DUR_W'(400)};
    endcase
    return w;
  endfunction

  // Pair counter modulo twelve, by a reciprocal multiply; exact for 0..127.
  function automatic logic [3:0] pair_mod12(input logic [PAIR_W-1:0] pair);
    logic [PAIR_W+8-1:0] prod;
    logic [3:0]          quo;
    logic [PAIR_W-1:0]   rem;
    prod = (PAIR_W+8)'(pair) * (PAIR_W+8)'(171);
    quo  = prod[PAIR_W+8-1:11];
    rem  = pair - PAIR_W'(quo) * PAIR_W'(12);
    return rem[3:0];
  endfunction

endpackage

@@ rtl/core/mts_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_rom
// Synchronous melody ROM holding compare and duration per note, with a registered read.
// ----------------------------------------------------------------------------
module mts_rom (
  input  logic               clk,
  input  mts_pkg::rom_req_t  req,
  output mts_pkg::rom_word_t rd_data
);
  import mts_pkg::*;

  rom_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_data_r <= melody_word(req.addr);
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/melody_tone_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_tone_sequencer
// Polled melody player: each step may advance to the next note and load a
// new tone compare value.
//
//   Channel  Direction  Contents
//   in_*     slave      alarm_active, splash_active, tick_now
//   out_*    master     sound_enable, compare_load, compare_value
//
// One step per clock unless output stalls; step stage, then output register.
// The ROM read for a step is issued when it is accepted, addressed with the
// note index forwarded from the step ahead of it.
// Reset is synchronous; the valid flags and the note state return to zero.
// A stalled output holds the step stage, and the input channel once that stage is full.
// ----------------------------------------------------------------------------
module melody_tone_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Bits from 0: alarm_active, splash_active, tick_now[31:0], zero fill.
  input  logic [mts_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Bits from 0: sound_enable, compare_load, compare_value[15:0], zero fill.
  output logic [mts_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mts_pkg::*;

  logic              s1_v_r, s1_v_nxt;
  logic              s1_alarm_r, s1_splash_r;
  logic [TICK_W-1:0] s1_tick_r;

  logic [PAIR_W-1:0] pair_r, pair_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;
  logic [CMP_W-1:0]  cmp_r, cmp_nxt;

  logic              out_v_r, out_v_nxt;
  logic              out_en_r, out_load_r;
  logic [CMP_W-1:0]  out_cmp_r;

  logic              in_acc, s1_adv, active, load;
  logic [TICK_W-1:0] elapsed;
  logic [PAIR_W-1:0] pair_fwd;
  rom_req_t          rom_req;
  rom_word_t         rom_q;

  mts_rom u_rom (
    .clk     (clk),
    .req     (rom_req),
    .rd_data (rom_q)
  );

  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign active  = s1_alarm_r || s1_splash_r;
  assign elapsed = s1_tick_r - start_r;
  assign load    = s1_v_r && active && (elapsed >= TICK_W'(dur_r));

  always_comb begin
    pair_nxt  = pair_r;
    dur_nxt   = dur_r;
    start_nxt = start_r;
    cmp_nxt   = cmp_r;
    if (load) begin
      pair_nxt  = pair_r + PAIR_W'(1);
      dur_nxt   = rom_q.duration;
      start_nxt = s1_tick_r;
      cmp_nxt   = rom_q.compare;
    end
  end

  assign pair_fwd = s1_v_r ? pair_nxt : pair_r;

  always_comb begin
    rom_req.en = in_acc;
    if (in_tdata[0]) begin
      rom_req.addr = {SEL_BIGBEN, pair_fwd[3:0]};
    end else begin
      rom_req.addr = {SEL_SPLASH, pair_mod12(pair_fwd)};
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_v_r && s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pair_r  <= '0;
      dur_r   <= '0;
      start_r <= '0;
      cmp_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_v_r && s1_adv) begin
        pair_r  <= pair_nxt;
        dur_r   <= dur_nxt;
        start_r <= start_nxt;
        cmp_r   <= cmp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_alarm_r  <= in_tdata[0];
      s1_splash_r <= in_tdata[1];
      s1_tick_r   <= in_tdata[TICK_W+1:2];
    end
    if (s1_v_r && s1_adv) begin
      out_en_r   <= active;
      out_load_r <= load;
      out_cmp_r  <= cmp_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_DATA_W-CMP_W-2)'(0), out_cmp_r, out_load_r, out_en_r};

  a_load_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_load_r) |-> out_en_r)
    else $error("compare load reported without sound enable");

  a_pair_holds_without_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv && !load) |=> $stable(pair_r))
    else $error("note index moved without a load");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input accepted while step stage is blocked");

  a_load_sets_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv && load) |=> (cmp_r == out_cmp_r))
    else $error("output compare differs from loaded state");

endmodule
